### hdl/crc8fr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the checked frame receiver.
package crc8fr_pkg;

	localparam int FRAME_BYTES_DEF = 17;
	localparam int MAX_PAYLOAD_DEF = 8;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam int LEN_W = 4;
	localparam int PAY_BYTES = 8;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic                   crc_ok;
		logic [15:0]            msg_type;
		logic [7:0]             rtr_flag;
		logic [31:0]            msg_id;
		logic [LEN_W-1:0]       payload_len;
		logic [8*PAY_BYTES-1:0] payload;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} q_push_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} q_head_t;

	typedef struct packed {
		logic full;
	} q_stat_t;

	// Reflected CRC-8, one byte, least significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### hdl/crc8fr_byte_if.sv
// Byte channel carrying received radio bytes.
interface crc8fr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/crc8fr_res_if.sv
// Result channel carrying one decoded frame per transfer.
interface crc8fr_res_if;
	logic        valid;
	logic        ready;
	logic        crc_ok;
	logic [15:0] msg_type;
	logic [7:0]  rtr_flag;
	logic [31:0] msg_id;
	logic [3:0]  payload_len;
	logic [63:0] payload;

	modport source (output valid, output crc_ok, output msg_type, output rtr_flag,
		output msg_id, output payload_len, output payload, input ready);
	modport sink (input valid, input crc_ok, input msg_type, input rtr_flag,
		input msg_id, input payload_len, input payload, output ready);
endinterface

### hdl/crc8_checked_frame_receiver_top.sv
// Top level of the CRC-8 checked frame receiver.
// Throughput: one byte transfer per cycle, sustained, while the result side keeps up.
// A frame result is offered from the output register after it has passed through the result queue.
// The two-entry result queue and the output register absorb stalls of the result side;
// byte transfers stop only when the last byte of a frame meets a full queue.
// Reset (arst_n, asynchronous, active low) clears the byte count, CRC and queue state.
module crc8_checked_frame_receiver_top #(
	parameter int FRAME_BYTES = crc8fr_pkg::FRAME_BYTES_DEF,
	parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	crc8fr_byte_if.sink   rx,
	crc8fr_res_if.source  result
);

	// Control between the three parts travels as small structs.
	crc8fr_pkg::q_push_t q_push;
	crc8fr_pkg::q_stat_t q_stat;
	crc8fr_pkg::q_head_t q_head;
	logic                pop;

	// The front end counts bytes, runs the CRC and, on the final byte of a frame,
	// decodes the stored bytes into one result which it pushes into the queue.
	crc8fr_front #(
		.FRAME_BYTES(FRAME_BYTES),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_stat (q_stat),
		.q_push (q_push)
	);

	// The queue decouples frame completion from the result side.
	crc8fr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (pop),
		.q_stat (q_stat),
		.q_head (q_head)
	);

	// The output stage holds each result until its transfer completes.
	crc8fr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (q_head),
		.pop    (pop),
		.result (result)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> (!q_stat.full || pop))
		else $error("result queue written while full");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> q_stat.full)
		else $error("byte side stalled without a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_head.valid)
		else $error("result queue read while empty");
	a_push_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push.valid && !q_head.valid && !result.valid) |=> q_head.valid)
		else $error("pushed result not visible at queue head");
`endif

endmodule

### hdl/crc8fr_front.sv
// Front end: takes bytes, keeps the running CRC and frame store, builds the frame result.
module crc8fr_front #(
	parameter int FRAME_BYTES = crc8fr_pkg::FRAME_BYTES_DEF,
	parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	crc8fr_byte_if.sink          rx,
	input  crc8fr_pkg::q_stat_t  q_stat,
	output crc8fr_pkg::q_push_t  q_push
);

	localparam int STORE_D = FRAME_BYTES - 1;
	localparam int IDX_W = $clog2(STORE_D);
	localparam int CNT_W = $clog2(FRAME_BYTES);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_BYTES - 1);
	localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD);

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       crc_q;
	logic [7:0]       store_q [0:STORE_D-1];
	logic [7:0]       crc_next;
	logic             is_last;
	logic             take;
	logic [7:0]       sb [0:15];
	logic [crc8fr_pkg::LEN_W-1:0] len;
	crc8fr_pkg::res_t res;

	assign is_last  = (cnt_q == LAST);
	assign rx.ready = !is_last || !q_stat.full;
	assign take     = rx.valid && rx.ready;
	assign crc_next = crc8fr_pkg::crc8_update(crc_q, rx.rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= '0;
		end else if (take) begin
			if (is_last) begin
				cnt_q <= '0;
				crc_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				crc_q <= crc_next;
			end
		end
	end

	// The last byte of a frame is only the check byte and is never stored.
	always_ff @(posedge clk) begin
		if (take && !is_last) begin
			store_q[cnt_q[IDX_W-1:0]] <= rx.rx_byte;
		end
	end

	// Bytes beyond the stored part of the frame read as zero.
	for (genvar i = 0; i < 16; i++) begin : g_sb
		if (i < STORE_D) begin : g_have
			assign sb[i] = store_q[i];
		end else begin : g_none
			assign sb[i] = '0;
		end
	end

	assign len = (sb[7] > LEN_MAX) ? crc8fr_pkg::LEN_W'(MAX_PAYLOAD)
		: sb[7][crc8fr_pkg::LEN_W-1:0];

	always_comb begin
		res = '0;
		if (crc_next == 8'h00) begin
			res.crc_ok      = 1'b1;
			res.msg_type    = {sb[0], sb[1]};
			res.rtr_flag    = sb[2];
			res.msg_id      = {sb[3], sb[4], sb[5], sb[6]};
			res.payload_len = len;
			for (int k = 0; k < crc8fr_pkg::PAY_BYTES; k++) begin
				if (crc8fr_pkg::LEN_W'(k) < len) begin
					res.payload[8*k +: 8] = sb[8+k];
				end
			end
		end
	end

	assign q_push.valid = take && is_last;
	assign q_push.res   = res;

endmodule

### hdl/crc8fr_queue.sv
// Short result queue between the front end and the output stage.
module crc8fr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crc8fr_pkg::q_push_t  q_push,
	input  logic                 pop,
	output crc8fr_pkg::q_stat_t  q_stat,
	output crc8fr_pkg::q_head_t  q_head
);

	localparam logic [crc8fr_pkg::Q_PTR_W:0] FULL_CNT = (crc8fr_pkg::Q_PTR_W + 1)'(crc8fr_pkg::Q_DEPTH);

	crc8fr_pkg::res_t mem_q [0:crc8fr_pkg::Q_DEPTH-1];
	logic [crc8fr_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [crc8fr_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [crc8fr_pkg::Q_PTR_W:0]   fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (q_push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({q_push.valid, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			mem_q[wr_ptr_q] <= q_push.res;
		end
	end

	assign q_stat.full  = (fill_q == FULL_CNT);
	assign q_head.valid = (fill_q != '0);
	assign q_head.res   = mem_q[rd_ptr_q];

endmodule

### hdl/crc8fr_back.sv
// Output stage: registers the queue head and presents it on the result channel.
module crc8fr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crc8fr_pkg::q_head_t  q_head,
	output logic                 pop,
	crc8fr_res_if.source         result
);

	logic             valid_q;
	crc8fr_pkg::res_t out_q;

	assign pop = q_head.valid && (!valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= pop || (valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_head.res;
		end
	end

	assign result.valid       = valid_q;
	assign result.crc_ok      = out_q.crc_ok;
	assign result.msg_type    = out_q.msg_type;
	assign result.rtr_flag    = out_q.rtr_flag;
	assign result.msg_id      = out_q.msg_id;
	assign result.payload_len = out_q.payload_len;
	assign result.payload     = out_q.payload;

endmodule
